### design/ecc_pkg.sv
// -----------------------------------------------------------------------------
// ecc_pkg
// Shared constants, status codes, calendar helpers and control structs for the
// epoch calendar converter.
// -----------------------------------------------------------------------------
`default_nettype none

package ecc_pkg;

  // opcodes
  localparam logic OpDateToSecs = 1'b0;
  localparam logic OpSecsToDate = 1'b1;

  // status codes
  localparam logic [2:0] StatusOk       = 3'd0;
  localparam logic [2:0] StatusBefore   = 3'd1;
  localparam logic [2:0] StatusAfter    = 3'd2;
  localparam logic [2:0] StatusRange    = 3'd3;
  localparam logic [2:0] StatusNegative = 3'd4;

  // field limits (years since 1900)
  localparam logic [7:0] YearEpoch   = 8'd70;
  localparam logic [7:0] YearLast    = 8'd138;
  localparam logic [3:0] MonthLast   = 4'd11;
  localparam logic [3:0] MonthCount  = 4'd12;
  localparam logic [4:0] DayLastLast = 5'd19;   // last day of Jan in the last year
  localparam logic [4:0] HourLast    = 5'd23;
  localparam logic [5:0] MinuteLast  = 6'd59;
  localparam logic [5:0] SecondLast  = 6'd59;

  localparam int unsigned SecsPerDay = 86400;
  localparam logic [31:0] SecsDay        = 32'(SecsPerDay);
  localparam logic [31:0] SecsHour       = 32'd3600;
  localparam logic [31:0] SecsMinute     = 32'd60;
  localparam logic [31:0] SecsCommonYear = 32'(365 * SecsPerDay);
  localparam logic [31:0] SecsLeapYear   = 32'(366 * SecsPerDay);
  localparam logic [31:0] Secs31Days     = 32'(31 * SecsPerDay);
  localparam logic [31:0] Secs30Days     = 32'(30 * SecsPerDay);
  localparam logic [31:0] Secs29Days     = 32'(29 * SecsPerDay);
  localparam logic [31:0] Secs28Days     = 32'(28 * SecsPerDay);

  // top bit index of the shift-and-add / restoring-divide steps
  localparam logic [2:0] DayTopBit    = 3'd4;
  localparam logic [2:0] HourTopBit   = 3'd4;
  localparam logic [2:0] MinuteTopBit = 3'd5;

  // Within 1970..2038 the century rules never bite (2000 is a leap year),
  // so a year since 1900 is leap exactly when it is a multiple of four.
  function automatic logic leap_year(input logic [7:0] yr);
    return (yr[1:0] == 2'b00);
  endfunction

  function automatic logic [31:0] month_secs(input logic [3:0] mon, input logic leap);
    logic [31:0] secs;
    unique case (mon)
      4'd1:                      secs = leap ? Secs29Days : Secs28Days;
      4'd3, 4'd5, 4'd8, 4'd10:   secs = Secs30Days;
      default:                   secs = Secs31Days;
    endcase
    return secs;
  endfunction

  typedef struct packed {
    logic        opcode;
    logic [2:0]  status;
    logic [7:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [30:0] seconds;
  } ecc_cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [30:0] seconds;
    logic [7:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } ecc_res_t;

endpackage

`default_nettype wire

### design/ecc_alu.sv
// -----------------------------------------------------------------------------
// ecc_alu
// Shared 32-bit add / subtract-compare unit used by every step of the
// sequencer.
// -----------------------------------------------------------------------------
`default_nettype none

module ecc_alu (
  input  wire logic [31:0] acc_i,
  input  wire logic [31:0] operand_i,
  input  wire logic        sub_i,
  output logic      [31:0] res_o,
  output logic             ge_o
);

  logic [32:0] sum;

  // sub: acc + ~op + 1, carry out set when acc >= op
  assign sum   = {1'b0, acc_i} + {1'b0, (sub_i ? ~operand_i : operand_i)} + 33'(sub_i);
  assign res_o = sum[31:0];
  assign ge_o  = sum[32];

endmodule

`default_nettype wire

### design/ecc_ctrl.sv
// -----------------------------------------------------------------------------
// ecc_ctrl
// Sequencer and working registers. Walks years, months, then day/hour/minute
// bits through the shared ALU, in add mode (date to seconds) or
// compare-subtract mode (seconds to date).
// -----------------------------------------------------------------------------
`default_nettype none

module ecc_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire ecc_pkg::ecc_cmd_t cmd_i,
  input  wire logic             take_i,
  output logic                  idle_o,
  output logic                  done_o,
  output ecc_pkg::ecc_res_t     res_o
);
  import ecc_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StYear  = 3'd1;
  localparam logic [2:0] StMonth = 3'd2;
  localparam logic [2:0] StDay   = 3'd3;
  localparam logic [2:0] StHour  = 3'd4;
  localparam logic [2:0] StMin   = 3'd5;
  localparam logic [2:0] StSec   = 3'd6;
  localparam logic [2:0] StDone  = 3'd7;

  logic [2:0]  state_q, state_d;
  logic        op_q, op_d;
  logic [2:0]  status_q, status_d;
  logic [31:0] acc_q, acc_d;
  logic [7:0]  yr_q, yr_d, tgt_yr_q, tgt_yr_d;
  logic [3:0]  mo_q, mo_d, tgt_mo_q, tgt_mo_d;
  logic [4:0]  day_q, day_d, hour_q, hour_d;
  logic [5:0]  min_q, min_d, sec_q, sec_d;
  logic [30:0] raw_q, raw_d;
  logic [2:0]  bit_q, bit_d;

  logic [31:0] operand;
  logic [31:0] alu_res;
  logic        alu_ge;
  logic        take;
  logic        phase_end;
  logic [2:0]  fin_status;
  logic        fin_ok;

  ecc_alu u_alu (
    .acc_i     (acc_q),
    .operand_i (operand),
    .sub_i     (op_q),
    .res_o     (alu_res),
    .ge_o      (alu_ge)
  );

  always_comb begin
    unique case (state_q)
      StYear:  operand = leap_year(yr_q) ? SecsLeapYear : SecsCommonYear;
      StMonth: operand = month_secs(mo_q, leap_year(yr_q));
      StDay:   operand = SecsDay << bit_q;
      StHour:  operand = SecsHour << bit_q;
      StMin:   operand = SecsMinute << bit_q;
      StSec:   operand = {26'd0, sec_q};
      default: operand = '0;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    status_d = status_q;
    acc_d    = acc_q;
    yr_d     = yr_q;
    tgt_yr_d = tgt_yr_q;
    mo_d     = mo_q;
    tgt_mo_d = tgt_mo_q;
    day_d    = day_q;
    hour_d   = hour_q;
    min_d    = min_q;
    sec_d    = sec_q;
    raw_d    = raw_q;
    bit_d    = bit_q;
    take     = 1'b0;
    phase_end = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          op_d     = cmd_i.opcode;
          status_d = cmd_i.status;
          acc_d    = (cmd_i.opcode == OpSecsToDate) ? {1'b0, cmd_i.seconds} : '0;
          raw_d    = cmd_i.seconds;
          yr_d     = YearEpoch;
          tgt_yr_d = cmd_i.year;
          mo_d     = '0;
          tgt_mo_d = cmd_i.month;
          day_d    = (cmd_i.opcode == OpSecsToDate) ? 5'd0 : (cmd_i.day - 5'd1);
          hour_d   = cmd_i.hour;
          min_d    = cmd_i.minute;
          sec_d    = cmd_i.second;
          state_d  = (cmd_i.status == StatusOk) ? StYear : StDone;
        end
      end
      StYear: begin
        phase_end = (op_q == OpSecsToDate) ? !alu_ge : (yr_q == tgt_yr_q);
        if (!phase_end) begin
          acc_d = alu_res;
          yr_d  = yr_q + 8'd1;
        end else begin
          state_d = StMonth;
        end
      end
      StMonth: begin
        phase_end = (op_q == OpSecsToDate) ? !alu_ge : (mo_q == tgt_mo_q);
        if (!phase_end) begin
          acc_d = alu_res;
          mo_d  = mo_q + 4'd1;
        end else begin
          state_d = StDay;
          bit_d   = DayTopBit;
        end
      end
      StDay: begin
        take  = (op_q == OpSecsToDate) ? alu_ge : day_q[4];
        if (take) acc_d = alu_res;
        day_d = {day_q[3:0], take};
        if (bit_q == 3'd0) begin
          state_d = StHour;
          bit_d   = HourTopBit;
        end else begin
          bit_d = bit_q - 3'd1;
        end
      end
      StHour: begin
        take   = (op_q == OpSecsToDate) ? alu_ge : hour_q[4];
        if (take) acc_d = alu_res;
        hour_d = {hour_q[3:0], take};
        if (bit_q == 3'd0) begin
          state_d = StMin;
          bit_d   = MinuteTopBit;
        end else begin
          bit_d = bit_q - 3'd1;
        end
      end
      StMin: begin
        take  = (op_q == OpSecsToDate) ? alu_ge : min_q[5];
        if (take) acc_d = alu_res;
        min_d = {min_q[4:0], take};
        if (bit_q == 3'd0) begin
          state_d = StSec;
        end else begin
          bit_d = bit_q - 3'd1;
        end
      end
      StSec: begin
        // date mode adds the seconds; seconds mode keeps the remainder
        if (op_q == OpDateToSecs) begin
          acc_d = alu_res;
        end else begin
          sec_d = acc_q[5:0];
        end
        state_d = StDone;
      end
      StDone: begin
        if (take_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    status_q <= status_d;
    acc_q    <= acc_d;
    yr_q     <= yr_d;
    tgt_yr_q <= tgt_yr_d;
    mo_q     <= mo_d;
    tgt_mo_q <= tgt_mo_d;
    day_q    <= day_d;
    hour_q   <= hour_d;
    min_q    <= min_d;
    sec_q    <= sec_d;
    raw_q    <= raw_d;
    bit_q    <= bit_d;
  end

  // late on the last day the sum spills past 31 bits
  assign fin_status = (status_q == StatusOk && op_q == OpDateToSecs && acc_q[31])
                      ? StatusAfter : status_q;
  assign fin_ok     = (fin_status == StatusOk);

  assign idle_o = (state_q == StIdle);
  assign done_o = (state_q == StDone);

  always_comb begin
    res_o.status  = fin_status;
    res_o.seconds = fin_ok ? ((op_q == OpSecsToDate) ? raw_q : acc_q[30:0]) : '0;
    res_o.year    = fin_ok ? yr_q : '0;
    res_o.month   = fin_ok ? mo_q : '0;
    res_o.day     = fin_ok ? (day_q + 5'd1) : '0;
    res_o.hour    = fin_ok ? hour_q : '0;
    res_o.minute  = fin_ok ? min_q : '0;
    res_o.second  = fin_ok ? sec_q : '0;
  end

  a_year_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StYear |-> yr_q <= YearLast)
    else $error("year counter past last year");

  a_month_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StMonth |-> mo_q < MonthCount)
    else $error("month counter ran past December");

  a_sec_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSec && op_q == OpSecsToDate) |-> acc_q < SecsMinute)
    else $error("remainder not below one minute");

  a_day_quotient: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone && op_q == OpSecsToDate && status_q == StatusOk) |-> day_q <= 5'd30)
    else $error("day quotient too large");

endmodule

`default_nettype wire

### design/epoch_calendar_converter_unit.sv
// -----------------------------------------------------------------------------
// epoch_calendar_converter_unit
// Converts between Gregorian date-time fields and seconds since 1970-01-01.
// -----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one request. opcode_i = 0
//   turns the date fields into seconds, opcode_i = 1 turns in_seconds_i into
//   date fields. Output channel (out_valid_o / out_ready_i) returns exactly one
//   result per request, with a status code; on error all other fields are 0.
//   A request in error skips the sequence. A valid one walks the years from
//   1970 one per cycle (up to 68 plus the step that ends the walk), the
//   months one per cycle (up to 11 plus one), then 5 + 5 + 6 bit steps for
//   day, hour and minute, one for the second, one to hand over and one in
//   the output register. All steps share one 32-bit add/compare-subtract
//   unit, which sets the rate: one request at a time, in_ready_o stays low
//   while the sequencer is busy. A finished result sits in the output
//   register; the sequencer may accept the next request while it waits. If
//   the receiver stalls, the next result waits in the sequencer until the
//   output register frees up. Reset (rst_ni low) empties the output
//   register and idles the sequencer.
// -----------------------------------------------------------------------------
`default_nettype none

module epoch_calendar_converter_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        opcode_i,
  input  wire logic [7:0]  in_year_i,
  input  wire logic [3:0]  in_month_i,
  input  wire logic [4:0]  in_day_i,
  input  wire logic [4:0]  in_hour_i,
  input  wire logic [5:0]  in_minute_i,
  input  wire logic [5:0]  in_second_i,
  input  wire logic signed [31:0] in_seconds_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [2:0]  status_o,
  output logic      [30:0] out_seconds_o,
  output logic      [7:0]  out_year_o,
  output logic      [3:0]  out_month_o,
  output logic      [4:0]  out_day_o,
  output logic      [4:0]  out_hour_o,
  output logic      [5:0]  out_minute_o,
  output logic      [5:0]  out_second_o
);
  import ecc_pkg::*;

  ecc_cmd_t cmd;
  ecc_res_t res;
  ecc_res_t res_q;
  logic     out_valid_q, out_valid_d;
  logic     ctrl_idle, ctrl_done;
  logic     start, load;
  logic [2:0] chk_status;

  // Range checks happen up front; an item in error skips the sequence.
  always_comb begin
    if (opcode_i == OpSecsToDate) begin
      chk_status = in_seconds_i[31] ? StatusNegative : StatusOk;
    end else begin
      priority if (in_year_i < YearEpoch) begin
        chk_status = StatusBefore;
      end else if (in_year_i > YearLast ||
                   (in_year_i == YearLast &&
                    (in_month_i != 4'd0 || in_day_i > DayLastLast))) begin
        chk_status = StatusAfter;
      end else if (in_month_i > MonthLast || in_day_i == 5'd0 ||
                   in_hour_i > HourLast || in_minute_i > MinuteLast ||
                   in_second_i > SecondLast) begin
        chk_status = StatusRange;
      end else begin
        chk_status = StatusOk;
      end
    end
  end

  always_comb begin
    cmd.opcode  = opcode_i;
    cmd.status  = chk_status;
    cmd.year    = in_year_i;
    cmd.month   = in_month_i;
    cmd.day     = in_day_i;
    cmd.hour    = in_hour_i;
    cmd.minute  = in_minute_i;
    cmd.second  = in_second_i;
    cmd.seconds = in_seconds_i[30:0];
  end

  assign in_ready_o = ctrl_idle;
  assign start      = in_valid_i && ctrl_idle;

  // result moves into the output register when it is empty or being drained
  assign load = ctrl_done && (!out_valid_q || out_ready_i);

  ecc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .cmd_i   (cmd),
    .take_i  (load),
    .idle_o  (ctrl_idle),
    .done_o  (ctrl_done),
    .res_o   (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) res_q <= res;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = res_q.status;
  assign out_seconds_o = res_q.seconds;
  assign out_year_o    = res_q.year;
  assign out_month_o   = res_q.month;
  assign out_day_o     = res_q.day;
  assign out_hour_o    = res_q.hour;
  assign out_minute_o  = res_q.minute;
  assign out_second_o  = res_q.second;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready stayed high after an input transfer");

  a_error_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != StatusOk) |->
      (out_seconds_o == '0 && out_year_o == '0 && out_day_o == '0))
    else $error("error result carries nonzero fields");

  a_ready_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !ctrl_done)
    else $error("sequencer idle and done at once");

endmodule

`default_nettype wire

### tb/tb_epoch_calendar_converter_unit.sv
// -----------------------------------------------------------------------------
// tb_epoch_calendar_converter_unit
// Self-checking bench for the epoch calendar converter: a directed table of
// calendar corners, then random date and seconds traffic under several
// idle/stall mixes, each checked against a pinned result or a built-in model.
// -----------------------------------------------------------------------------
module tb_epoch_calendar_converter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ecc_pkg::*;

  // Tail wait after draining, for stray results.
  localparam int unsigned TailCycles   = 200;
  localparam int unsigned HoldOffLen   = 400;
  localparam int unsigned PhaseItems   = 232;
  localparam int unsigned MaxReported  = 10;
  localparam int unsigned FirstYear    = 1970;
  localparam int unsigned MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // One request as it goes over the input channel.
  typedef struct packed {
    logic        opcode;
    logic [7:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [31:0] seconds;
  } conv_req_t;

  // Directed row: the result is typed in only when pinned is set.
  typedef struct {
    conv_req_t req;
    bit        pinned;
    ecc_res_t  want;
  } stim_row_t;

  logic        clk;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic        opcode       = 1'b0;
  logic [7:0]  in_year      = '0;
  logic [3:0]  in_month     = '0;
  logic [4:0]  in_day       = '0;
  logic [4:0]  in_hour      = '0;
  logic [5:0]  in_minute    = '0;
  logic [5:0]  in_second    = '0;
  logic [31:0] in_seconds   = '0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [2:0]  status;
  logic [30:0] out_seconds;
  logic [7:0]  out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;

  ecc_res_t    expected_dates [$];
  int unsigned mismatch_count  = 0;
  int unsigned send_idle_pct   = 0;
  int unsigned recv_stall_pct  = 0;
  bit          hold_off_pending = 1'b0;

  epoch_calendar_converter_unit i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .opcode_i      (opcode),
    .in_year_i     (in_year),
    .in_month_i    (in_month),
    .in_day_i      (in_day),
    .in_hour_i     (in_hour),
    .in_minute_i   (in_minute),
    .in_second_i   (in_second),
    .in_seconds_i  (in_seconds),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (status),
    .out_seconds_o (out_seconds),
    .out_year_o    (out_year),
    .out_month_o   (out_month),
    .out_day_o     (out_day),
    .out_hour_o    (out_hour),
    .out_minute_o  (out_minute),
    .out_second_o  (out_second)
  );

  // ---------------------------------------------------------------------------
  // Calendar model
  // ---------------------------------------------------------------------------

  // Full Gregorian rule, on the full year number.
  function automatic bit is_leap(int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  function automatic int unsigned year_length(int unsigned yr);
    return is_leap(yr) ? 366 : 365;
  endfunction

  function automatic int unsigned month_length(int unsigned mon, int unsigned yr);
    return MonthDays[mon] + ((mon == 1 && is_leap(yr)) ? 1 : 0);
  endfunction

  function automatic ecc_res_t predict_conversion(conv_req_t rq);
    ecc_res_t          r;
    int unsigned       full_year;
    int unsigned       k;
    int unsigned       yr;
    int unsigned       mon;
    longint unsigned   day_count;
    longint unsigned   total;
    logic [31:0]       rem;
    r = '0;
    if (rq.opcode == OpDateToSecs) begin
      // Check order matters: early year wins over late year wins over range.
      if (rq.year < YearEpoch) begin
        r.status = StatusBefore;
      end else if (rq.year > YearLast ||
                   (rq.year == YearLast && (rq.month >= 1 || rq.day > DayLastLast))) begin
        r.status = StatusAfter;
      end else if (rq.month > MonthLast || rq.day == 0 || rq.hour > HourLast ||
                   rq.minute > MinuteLast || rq.second > SecondLast) begin
        r.status = StatusRange;
      end else begin
        full_year = 1900 + rq.year;
        day_count = 0;
        for (k = FirstYear; k < full_year; k++) day_count += year_length(k);
        // Day is only checked against 1..31, so a short month rolls over.
        for (k = 0; k < rq.month; k++) day_count += month_length(k, full_year);
        day_count += rq.day - 1;
        total = day_count * SecsPerDay + rq.hour * 3600 + rq.minute * 60 + rq.second;
        if (total > 64'h7FFF_FFFF) begin
          // Late on 2038-01-19: does not fit 31 bits.
          r.status = StatusAfter;
        end else begin
          r.status  = StatusOk;
          r.seconds = 31'(total);
          r.year    = rq.year;
          r.month   = rq.month;
          r.day     = rq.day;
          r.hour    = rq.hour;
          r.minute  = rq.minute;
          r.second  = rq.second;
        end
      end
    end else if (rq.seconds[31]) begin
      r.status = StatusNegative;
    end else begin
      rem = rq.seconds;
      yr  = FirstYear;
      while (year_length(yr) * SecsPerDay <= rem) begin
        rem -= year_length(yr) * SecsPerDay;
        yr++;
      end
      mon = 0;
      while (mon < 12 && month_length(mon, yr) * SecsPerDay <= rem) begin
        rem -= month_length(mon, yr) * SecsPerDay;
        mon++;
      end
      r.status  = StatusOk;
      r.seconds = rq.seconds[30:0];
      r.year    = 8'(yr - 1900);
      r.month   = 4'(mon);
      r.day     = 5'(1 + rem / SecsPerDay);
      rem       = rem % SecsPerDay;
      r.hour    = 5'(rem / 3600);
      rem       = rem % 3600;
      r.minute  = 6'(rem / 60);
      r.second  = 6'(rem % 60);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table: calendar corners, every error code, both opcodes
  // ---------------------------------------------------------------------------
  stim_row_t directed_rows [$] = '{
    // epoch itself and the very last second that fits
    '{'{OpDateToSecs, 8'd70, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0, 32'd0}, 1'b1,
      '{StatusOk, 31'd0, 8'd70, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0}},
    '{'{OpDateToSecs, 8'd138, 4'd0, 5'd19, 5'd3, 6'd14, 6'd7, 32'd0}, 1'b1,
      '{StatusOk, 31'h7FFF_FFFF, 8'd138, 4'd0, 5'd19, 5'd3, 6'd14, 6'd7}},
    // one second too late on the last day, then past the last day
    '{'{OpDateToSecs, 8'd138, 4'd0, 5'd19, 5'd3, 6'd14, 6'd8, 32'd0}, 1'b1,
      '{status: StatusAfter, default: '0}},
    '{'{OpDateToSecs, 8'd138, 4'd0, 5'd20, 5'd0, 6'd0, 6'd0, 32'd0}, 1'b1,
      '{status: StatusAfter, default: '0}},
    '{'{OpDateToSecs, 8'd138, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'd0}, 1'b1,
      '{status: StatusAfter, default: '0}},
    '{'{OpDateToSecs, 8'd139, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0, 32'd0}, 1'b1,
      '{status: StatusAfter, default: '0}},
    // year checks come before the field range check
    '{'{OpDateToSecs, 8'd255, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 32'hFFFF_FFFF}, 1'b1,
      '{status: StatusAfter, default: '0}},
    '{'{OpDateToSecs, 8'd69, 4'd11, 5'd31, 5'd23, 6'd59, 6'd59, 32'd0}, 1'b1,
      '{status: StatusBefore, default: '0}},
    '{'{OpDateToSecs, 8'd0, 4'd15, 5'd0, 5'd31, 6'd63, 6'd63, 32'd0}, 1'b1,
      '{status: StatusBefore, default: '0}},
    // each field out of its limits
    '{'{OpDateToSecs, 8'd100, 4'd12, 5'd1, 5'd0, 6'd0, 6'd0, 32'd0}, 1'b1,
      '{status: StatusRange, default: '0}},
    '{'{OpDateToSecs, 8'd100, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd0}, 1'b1,
      '{status: StatusRange, default: '0}},
    '{'{OpDateToSecs, 8'd100, 4'd0, 5'd1, 5'd24, 6'd0, 6'd0, 32'd0}, 1'b1,
      '{status: StatusRange, default: '0}},
    '{'{OpDateToSecs, 8'd100, 4'd0, 5'd1, 5'd0, 6'd60, 6'd0, 32'd0}, 1'b1,
      '{status: StatusRange, default: '0}},
    '{'{OpDateToSecs, 8'd100, 4'd0, 5'd1, 5'd0, 6'd0, 6'd63, 32'd0}, 1'b1,
      '{status: StatusRange, default: '0}},
    // leap days, short-month rollover, year ends
    '{'{OpDateToSecs, 8'd72, 4'd1, 5'd29, 5'd12, 6'd30, 6'd45, 32'd0}, 1'b0, '0},
    '{'{OpDateToSecs, 8'd71, 4'd1, 5'd31, 5'd0, 6'd0, 6'd0, 32'd0}, 1'b0, '0},
    '{'{OpDateToSecs, 8'd100, 4'd1, 5'd29, 5'd6, 6'd0, 6'd1, 32'd0}, 1'b0, '0},
    '{'{OpDateToSecs, 8'd99, 4'd11, 5'd31, 5'd23, 6'd59, 6'd59, 32'd0}, 1'b0, '0},
    '{'{OpDateToSecs, 8'd137, 4'd11, 5'd31, 5'd23, 6'd59, 6'd59, 32'd0}, 1'b0, '0},
    // seconds to date: zero, largest, negative, and date fields left as noise
    '{'{OpSecsToDate, 8'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd0}, 1'b1,
      '{StatusOk, 31'd0, 8'd70, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0}},
    '{'{OpSecsToDate, 8'd255, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 32'h7FFF_FFFF}, 1'b1,
      '{StatusOk, 31'h7FFF_FFFF, 8'd138, 4'd0, 5'd19, 5'd3, 6'd14, 6'd7}},
    '{'{OpSecsToDate, 8'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'hFFFF_FFFF}, 1'b1,
      '{status: StatusNegative, default: '0}},
    '{'{OpSecsToDate, 8'd255, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 32'h8000_0000}, 1'b1,
      '{status: StatusNegative, default: '0}},
    '{'{OpSecsToDate, 8'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd951782400}, 1'b0, '0},
    '{'{OpSecsToDate, 8'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd1230767999}, 1'b0, '0}
  };

  // ---------------------------------------------------------------------------
  // Clock, timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Well past the slowest passing run, stalls included.
  initial begin
    #1_000_000;
    $display("epoch_calendar_converter_unit regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Called right after a posedge. Idles at random, then presents the request
  // at a falling edge and holds it until the transfer happens. Valid is left
  // high on return so back-to-back requests never drop it within one step.
  task automatic offer_request(input conv_req_t rq, input ecc_res_t want);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= rq.opcode;
    in_year    <= rq.year;
    in_month   <= rq.month;
    in_day     <= rq.day;
    in_hour    <= rq.hour;
    in_minute  <= rq.minute;
    in_second  <= rq.second;
    in_seconds <= rq.seconds;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_dates.insert(expected_dates.size(), want);
  endtask

  // Drop valid and let the block empty out completely.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    conv_req_t   rq;
    conv_req_t   boundary_req;
    int unsigned pick;
    // idle percentages per phase: none, sender, receiver, both
    int unsigned phase_send [4];
    int unsigned phase_recv [4];

    phase_send = '{0, 80, 0, 25};
    phase_recv = '{0, 0, 80, 25};

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      offer_request(directed_rows[r].req, directed_rows[r].pinned ?
                    directed_rows[r].want : predict_conversion(directed_rows[r].req));
    end

    for (int ph = 0; ph < 4; ph++) begin
      // Sender pauses here until every outstanding result is back.
      wait_drained();
      send_idle_pct  = phase_send[ph];
      recv_stall_pct = phase_recv[ph];
      for (int unsigned i = 0; i < PhaseItems; i++) begin
        // Start from noise in every field; unused fields stay noisy.
        rq.opcode  = 1'($urandom);
        rq.year    = 8'($urandom);
        rq.month   = 4'($urandom);
        rq.day     = 5'($urandom);
        rq.hour    = 5'($urandom);
        rq.minute  = 6'($urandom);
        rq.second  = 6'($urandom);
        rq.seconds = $urandom;
        pick = $urandom_range(99);
        if (pick < 45) begin
          // well-formed date, every day 1..31 allowed so short months roll
          rq.opcode = OpDateToSecs;
          rq.year   = 8'($urandom_range(YearLast, YearEpoch));
          rq.month  = 4'($urandom_range(MonthLast));
          rq.day    = 5'($urandom_range(31, 1));
          rq.hour   = 5'($urandom_range(HourLast));
          rq.minute = 6'($urandom_range(MinuteLast));
          rq.second = 6'($urandom_range(SecondLast));
          if (pick < 6) begin
            // around the end of the range in January 2038
            rq.year  = YearLast;
            rq.month = 4'd0;
            rq.day   = 5'($urandom_range(20, 18));
          end
        end else if (pick < 70) begin
          rq.opcode  = OpSecsToDate;
          rq.seconds = {1'b0, 31'($urandom)};
        end else if (pick < 82) begin
          // at a month start or one second either side of it
          boundary_req        = '0;
          boundary_req.opcode = OpDateToSecs;
          boundary_req.year   = 8'($urandom_range(YearLast - 1, YearEpoch));
          boundary_req.month  = 4'($urandom_range(MonthLast));
          boundary_req.day    = 5'd1;
          rq.opcode  = OpSecsToDate;
          rq.seconds = 32'(predict_conversion(boundary_req).seconds) +
                       32'($urandom_range(2)) - 32'd1;
        end
        offer_request(rq, predict_conversion(rq));
        // Long receiver hold-off while the sender keeps pushing: the output
        // register and the sequencer both fill and in_ready must drop.
        if (ph == 0 && i == 40) hold_off_pending = 1'b1;
      end
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("epoch_calendar_converter_unit regression: pass");
    end else begin
      $display("epoch_calendar_converter_unit regression: fail");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Ready changes at falling edges only; the hold-off is counted here.
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        hold_left = HoldOffLen;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic string show_result(ecc_res_t r);
    return $sformatf("st=%0d secs=%0d y=%0d m=%0d d=%0d %0d:%0d:%0d", r.status,
                     r.seconds, r.year, r.month, r.day, r.hour, r.minute, r.second);
  endfunction

  // Every output transfer must match the oldest expectation, field by field.
  always @(posedge clk) begin
    ecc_res_t got;
    ecc_res_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{status, out_seconds, out_year, out_month, out_day,
              out_hour, out_minute, out_second};
      if (expected_dates.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReported) begin
          $display("%0t: result with nothing outstanding: %s", $realtime, show_result(got));
        end
      end else begin
        want = expected_dates.pop_front();
        if (got.status !== want.status || got.seconds !== want.seconds ||
            got.year !== want.year || got.month !== want.month ||
            got.day !== want.day || got.hour !== want.hour ||
            got.minute !== want.minute || got.second !== want.second) begin
          mismatch_count++;
          if (mismatch_count <= MaxReported) begin
            $display("%0t: mismatch want %s", $realtime, show_result(want));
            $display("%0t:          got  %s", $realtime, show_result(got));
          end
        end
      end
    end
  end

endmodule
